>>> design/nvts_pkg.sv
// Shared types and constants for the nearest-value table search block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nvts_pkg;

  // Table geometry and value format (signed Q7.24).
  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;

  // Operation codes carried on the input channel.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One input item.
  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          entry_index;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [IDX_W-1:0] nearest_index;
    logic             found;
  } out_item_t;

  // Request from the sequencer to the table memory.
  typedef struct packed {
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
  } mem_req_t;

  // Flags returned by the shared compare unit.
  typedef struct packed {
    logic eq;
    logic gt;
    logic lt;
    logic above;
  } cmp_res_t;

endpackage

`default_nettype wire

>>> design/nearest_value_table_search.sv
// Top level of the nearest-value table search block: configuration
// register, sequencer, shared compare unit and table memory.
// Depends on nvts_pkg, nvts_mem, nvts_cmp and nvts_seq.
//
//   Channel  Ports                          Payload
//   input    in_valid / in_ready            in_data   (in_item_t)
//   result   out_valid / out_ready          out_data  (out_item_t)
//   config   cfg_valid / cfg_ready          cfg_data  (entry_count, 11 bits)
//
// A table write keeps the block idle. A query holds the block until
// its result is loaded into the output register: one memory read per
// search step, set by the single read port of the table memory.
// Reset is synchronous and active low; the table contents are not cleared.
// A result waits in the output register while the block keeps working;
// a second result waits for that transfer before the block goes idle.
`timescale 1ns / 1ps
`default_nettype none

module nearest_value_table_search
  import nvts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0]          count_r;
  logic [IDX_W-1:0]          last_idx;
  mem_req_t                  mem_req;
  logic signed [VALUE_W-1:0] rd_data;
  cmp_res_t                  cmp;
  logic signed [VALUE_W-1:0] cmp_x;
  logic signed [VALUE_W-1:0] cmp_a;
  logic signed [VALUE_W-1:0] cmp_b;

  assign cfg_ready = 1'b1;

  // Entry count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_data;
    end
  end

  // Last index in use: a zero count acts as one, a large count saturates.
  always_comb begin
    if (count_r == '0) begin
      last_idx = '0;
    end else if (count_r > CNT_W'(TABLE_DEPTH)) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(count_r - 1'b1);
    end
  end

  nvts_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .last_idx  (last_idx),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .cmp       (cmp),
    .cmp_x     (cmp_x),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b)
  );

  nvts_cmp u_cmp (
    .x   (cmp_x),
    .y   (rd_data),
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  nvts_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

>>> design/nvts_mem.sv
// Table memory: one write port and one registered read port.
// Depends on nvts_pkg for the depth, widths and request struct.
`timescale 1ns / 1ps
`default_nettype none

module nvts_mem
  import nvts_pkg::*;
(
  input  wire logic                      clk,
  input  wire mem_req_t                  mem_req,
  output logic signed [VALUE_W-1:0]      rd_data
);

  logic signed [VALUE_W-1:0] mem_r [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem_r[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem_r[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> design/nvts_cmp.sv
// Shared compare unit: orders the query against one entry and tests
// the query against the midpoint of two neighbors exactly (2x > a + b).
// Depends on nvts_pkg for the value width and flag struct.
`timescale 1ns / 1ps
`default_nettype none

module nvts_cmp
  import nvts_pkg::*;
(
  input  wire logic signed [VALUE_W-1:0] x,
  input  wire logic signed [VALUE_W-1:0] y,
  input  wire logic signed [VALUE_W-1:0] a,
  input  wire logic signed [VALUE_W-1:0] b,
  output cmp_res_t                       res
);

  logic signed [VALUE_W:0] two_x;
  logic signed [VALUE_W:0] sum_ab;

  // One extra bit keeps both sides of the midpoint test exact.
  assign two_x  = {x, 1'b0};
  assign sum_ab = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};

  assign res.eq    = (x == y);
  assign res.gt    = (x > y);
  assign res.lt    = (x < y);
  assign res.above = (two_x > sum_ab);

endmodule

`default_nettype wire

>>> design/nvts_seq.sv
// Search sequencer: loads table entries, runs the range check and the
// binary search over the table memory, and holds the result register.
// Depends on nvts_pkg; drives nvts_mem and uses the nvts_cmp flags.
`timescale 1ns / 1ps
`default_nettype none

module nvts_seq
  import nvts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire in_item_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output out_item_t                      out_data,
  input  wire logic [IDX_W-1:0]          last_idx,
  output mem_req_t                       mem_req,
  input  wire logic signed [VALUE_W-1:0] rd_data,
  input  wire cmp_res_t                  cmp,
  output logic signed [VALUE_W-1:0]      cmp_x,
  output logic signed [VALUE_W-1:0]      cmp_a,
  output logic signed [VALUE_W-1:0]      cmp_b
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SRCH,
    S_FIN,
    S_PUSH
  } state_t;

  state_t                    state_r;
  logic signed [VALUE_W-1:0] x_r;
  logic signed [VALUE_W-1:0] a_r;
  logic signed [VALUE_W-1:0] b_r;
  logic [IDX_W-1:0]          left_r;
  logic [IDX_W-1:0]          right_r;
  logic [IDX_W-1:0]          mid_r;
  logic                      lo_fail_r;
  logic [IDX_W-1:0]          res_idx_r;
  logic                      res_found_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic [IDX_W-1:0]          left_nxt;
  logic [IDX_W-1:0]          right_nxt;
  logic [IDX_W:0]            mid_sum;
  logic [IDX_W-1:0]          mid_nxt;
  logic                      more;
  logic                      out_of_range;
  logic                      in_xfer;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmp_x = x_r;
  assign cmp_a = a_r;
  assign cmp_b = b_r;

  // A query fails the range check below the first or above the last entry.
  assign out_of_range = lo_fail_r || cmp.gt;

  // Next search bounds: initial bounds after the range check, else
  // move the bound on the side that the query does not lie on.
  always_comb begin
    if (state_r == S_LAST) begin
      left_nxt  = '0;
      right_nxt = last_idx;
    end else if (cmp.gt) begin
      left_nxt  = mid_r;
      right_nxt = right_r;
    end else begin
      left_nxt  = left_r;
      right_nxt = mid_r;
    end
  end

  assign mid_sum = {1'b0, left_nxt} + {1'b0, right_nxt};
  assign mid_nxt = mid_sum[IDX_W:1];
  assign more    = (({1'b0, left_nxt} + 1'b1) < {1'b0, right_nxt});

  // Memory requests: entry writes from idle, reads as the search steps.
  always_comb begin
    mem_req.wr_en   = in_xfer && (in_data.operation == OP_WRITE);
    mem_req.wr_addr = in_data.entry_index;
    mem_req.wr_data = in_data.sample_value;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = '0;
    unique case (state_r)
      S_IDLE: begin
        mem_req.rd_en = in_xfer && (in_data.operation == OP_QUERY);
      end
      S_FIRST: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = last_idx;
      end
      S_LAST: begin
        mem_req.rd_en   = !out_of_range && more;
        mem_req.rd_addr = mid_nxt;
      end
      S_SRCH: begin
        mem_req.rd_en   = !cmp.eq && more;
        mem_req.rd_addr = mid_nxt;
      end
      S_FIN, S_PUSH: begin
        mem_req.rd_en = 1'b0;
      end
      default: begin
        mem_req.rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer state, search registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The output register empties on a transfer unless a new result loads it.
      if (out_valid_r && out_ready && (state_r != S_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_data.operation == OP_QUERY)) begin
            x_r     <= in_data.sample_value;
            state_r <= S_FIRST;
          end
        end
        S_FIRST: begin
          a_r       <= rd_data;
          lo_fail_r <= cmp.lt;
          state_r   <= S_LAST;
        end
        S_LAST: begin
          b_r <= rd_data;
          if (out_of_range) begin
            res_idx_r   <= '0;
            res_found_r <= 1'b0;
            state_r     <= S_PUSH;
          end else begin
            left_r  <= left_nxt;
            right_r <= right_nxt;
            mid_r   <= mid_nxt;
            state_r <= more ? S_SRCH : S_FIN;
          end
        end
        S_SRCH: begin
          if (cmp.eq) begin
            res_idx_r   <= mid_r;
            res_found_r <= 1'b1;
            state_r     <= S_PUSH;
          end else begin
            if (cmp.gt) begin
              a_r <= rd_data;
            end else begin
              b_r <= rd_data;
            end
            left_r  <= left_nxt;
            right_r <= right_nxt;
            mid_r   <= mid_nxt;
            state_r <= more ? S_SRCH : S_FIN;
          end
        end
        S_FIN: begin
          // A tie at the midpoint keeps the lower index.
          res_idx_r   <= cmp.above ? right_r : left_r;
          res_found_r <= 1'b1;
          state_r     <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.nearest_index <= res_idx_r;
            out_data_r.found         <= res_found_r;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The probe index always lies strictly inside the current bounds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> ((left_r < mid_r) && (mid_r < right_r)))
    else $error("search probe outside its bounds");

  // The upper bound never leaves the entries in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_FIN) |-> (right_r <= last_idx))
    else $error("search bound beyond last entry");

  // A found result names an entry in use; a miss reports index zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |->
      (res_found_r ? (res_idx_r <= last_idx) : (res_idx_r == '0)))
    else $error("result index inconsistent with found flag");

  // A new result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_PUSH && state_r == S_IDLE && $past(out_valid_r))
      |-> $past(out_ready))
    else $error("result overwrote an untaken transfer");

endmodule

`default_nettype wire
